>>> hdl/mpfa_pkg.sv
// Shared constants, register indexes and control types of the frame assembler.
`timescale 1ns / 1ps

package mpfa_pkg;

    localparam int PORTS_DEF       = 6;
    localparam int FRAME_BYTES_DEF = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_PORT_MODES    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_BYTES    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_BYTES    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_LENGTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 3'd4;

    localparam logic [1:0] MODE_HEAD_TAIL = 2'd0;
    localparam logic [1:0] MODE_TAIL_ONLY = 2'd1;
    localparam logic [1:0] MODE_HEAD_LEN  = 2'd2;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam int PORT_W = 3;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 5;
    localparam int LEN_W  = 6;

    localparam logic [LEN_W-1:0]  FIXED_LENGTH_RST  = 6'd8;
    localparam logic [15:0]       TIMEOUT_TICKS_RST = 16'd10;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // capture the input word
        logic eval;     // process the captured word
        logic rd;       // issue a frame store read
        logic ld;       // load the output register
    } mpfa_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic emit;     // evaluated byte completes a frame
        logic last;     // read position is the final byte
        logic out_free; // output register can take a word this cycle
    } mpfa_stat_t;

endpackage

>>> hdl/multi_port_frame_assembler.sv
// Flow: an input word is captured, then evaluated; a word that completes a frame is read
// out byte by byte from the frame store into the output register, which can stall it.
// Input waits until readout ends, set by the single read port of the frame store.
// Reset: asynchronous, active low; clears fill counts, byte times, the tick counter,
// configuration and handshake state. Frame store contents are not cleared.
`timescale 1ns / 1ps

module multi_port_frame_assembler #(
    parameter int PORTS       = mpfa_pkg::PORTS_DEF,
    parameter int FRAME_BYTES = mpfa_pkg::FRAME_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mpfa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mpfa_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,  // port[2:0], rx_byte[10:3], zero pad
    input  logic                             s_tuser,  // op
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [23:0]                      m_tdata,  // frame_port[2:0], frame_byte[10:3],
                                                       // byte_position[15:11],
                                                       // frame_length[21:16], zero pad
    output logic                             m_tlast   // last_byte
);
    import mpfa_pkg::*;

    mpfa_cmd_t         cmd;
    mpfa_stat_t        stat;
    logic [PORT_W-1:0] out_port;
    logic [BYTE_W-1:0] out_byte;
    logic [POS_W-1:0]  out_pos;
    logic [LEN_W-1:0]  out_len;

    assign cfg_ready = 1'b1;

    mpfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mpfa_dp #(
        .PORTS       (PORTS),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_op     (s_tuser),
        .in_port   (s_tdata[2:0]),
        .in_byte   (s_tdata[10:3]),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_port  (out_port),
        .out_byte  (out_byte),
        .out_pos   (out_pos),
        .out_len   (out_len),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, out_len, out_pos, out_byte, out_port};

endmodule

>>> hdl/mpfa_ctrl.sv
// Controller state machine: sequences evaluation and frame readout.
`timescale 1ns / 1ps

module mpfa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mpfa_pkg::mpfa_stat_t stat,
    output mpfa_pkg::mpfa_cmd_t  cmd
);
    import mpfa_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;
    localparam logic [1:0] ST_LD   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = stat.emit ? ST_RD : ST_IDLE;
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_LD;
            end
            ST_LD:
            begin
                // hold the read word until the output register frees up
                if (stat.out_free)
                begin
                    cmd.ld     = 1'b1;
                    state_next = stat.last ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/mpfa_dp.sv
// Datapath: configuration, per-port fill state, frame store and output register.
`timescale 1ns / 1ps

module mpfa_dp #(
    parameter int PORTS       = mpfa_pkg::PORTS_DEF,
    parameter int FRAME_BYTES = mpfa_pkg::FRAME_BYTES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mpfa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mpfa_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_op,
    input  logic [mpfa_pkg::PORT_W-1:0]          in_port,
    input  logic [mpfa_pkg::BYTE_W-1:0]          in_byte,
    input  mpfa_pkg::mpfa_cmd_t                  cmd,
    output mpfa_pkg::mpfa_stat_t                 stat,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [mpfa_pkg::PORT_W-1:0]          out_port,
    output logic [mpfa_pkg::BYTE_W-1:0]          out_byte,
    output logic [mpfa_pkg::POS_W-1:0]           out_pos,
    output logic [mpfa_pkg::LEN_W-1:0]           out_len,
    output logic                                 out_last
);
    import mpfa_pkg::*;

    localparam int PI_W   = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int FC_W   = $clog2(FRAME_BYTES + 1);
    localparam int DEPTH  = PORTS * FRAME_BYTES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [FC_W-1:0] FILL_MAX = FC_W'(FRAME_BYTES - 1);
    localparam logic [FC_W-1:0] FILL_FB  = FC_W'(FRAME_BYTES);
    localparam logic [FC_W-1:0] FILL_TWO = FC_W'(2);

    // configuration
    logic [11:0]       port_modes_reg;
    logic [47:0]       head_bytes_reg;
    logic [47:0]       tail_bytes_reg;
    logic [LEN_W-1:0]  fixed_length_reg;
    logic [15:0]       timeout_ticks_reg;

    // captured input word
    logic              op_reg;
    logic [PORT_W-1:0] port_reg;
    logic [BYTE_W-1:0] byte_reg;

    // per-port state
    logic [FC_W-1:0]   fill_reg [PORTS];
    logic [31:0]       seen_reg [PORTS];
    logic [31:0]       tick_reg;

    // frame store
    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // readout
    logic [PORT_W-1:0] emit_port_reg;
    logic [FC_W-1:0]   emit_len_reg;
    logic [FC_W-1:0]   pos_reg;

    // output register
    logic              out_valid_reg;
    logic [PORT_W-1:0] out_port_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_last_reg;

    // evaluation results
    logic              port_ok;
    logic [PI_W-1:0]   pidx;
    logic [1:0]        mode;
    logic [7:0]        head;
    logic [7:0]        tail;
    logic [FC_W-1:0]   n_cur;
    logic [FC_W-1:0]   n_eff;
    logic [FC_W-1:0]   n_inc;
    logic [FC_W-1:0]   flen;
    logic [31:0]       idle_ticks;
    logic              wr_en;
    logic [FC_W-1:0]   wr_idx;
    logic [FC_W-1:0]   fill_new;
    logic              emit;
    logic [FC_W-1:0]   emit_len;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    always_comb
    begin
        port_ok    = (int'(port_reg) < PORTS);
        pidx       = PI_W'(port_reg);
        mode       = 2'((port_modes_reg >> (2 * port_reg)) & 12'h3);
        head       = 8'((head_bytes_reg >> (8 * port_reg)) & 48'hFF);
        tail       = 8'((tail_bytes_reg >> (8 * port_reg)) & 48'hFF);
        n_cur      = port_ok ? fill_reg[pidx] : '0;
        idle_ticks = tick_reg - (port_ok ? seen_reg[pidx] : 32'd0);
        // drop a partial frame that went idle too long
        n_eff      = ((n_cur != '0) && (idle_ticks > {16'd0, timeout_ticks_reg})) ? '0 : n_cur;
        n_inc      = n_eff + FC_W'(1);
        if (int'(fixed_length_reg) < 2)
        begin
            flen = FILL_TWO;
        end
        else if (int'(fixed_length_reg) > FRAME_BYTES)
        begin
            flen = FILL_FB;
        end
        else
        begin
            flen = FC_W'(fixed_length_reg);
        end

        wr_en    = 1'b0;
        wr_idx   = n_eff;
        fill_new = '0;
        emit     = 1'b0;
        emit_len = n_inc;

        if (mode == MODE_TAIL_ONLY)
        begin
            if (n_eff < FILL_MAX)
            begin
                wr_en = 1'b1;
                if (byte_reg == tail)
                begin
                    emit = (n_inc >= FILL_TWO);
                end
                else
                begin
                    fill_new = n_inc;
                end
            end
        end
        else if (n_eff == '0)
        begin
            // wait for the head byte
            if (byte_reg == head)
            begin
                wr_en    = 1'b1;
                fill_new = FC_W'(1);
            end
        end
        else if (mode == MODE_HEAD_LEN)
        begin
            if (n_eff < flen)
            begin
                wr_en = 1'b1;
                if (n_inc >= flen)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    fill_new = n_inc;
                end
            end
        end
        else if (byte_reg != tail)
        begin
            if (n_eff < FILL_MAX)
            begin
                wr_en    = 1'b1;
                fill_new = n_inc;
            end
        end
        else if ((n_eff >= FILL_TWO) && (n_eff < FILL_FB))
        begin
            wr_en = 1'b1;
            emit  = 1'b1;
        end

        if ((op_reg != OP_BYTE) || !port_ok)
        begin
            wr_en = 1'b0;
            emit  = 1'b0;
        end

        wr_addr = ADDR_W'(int'(port_reg) * FRAME_BYTES + int'(wr_idx));
        rd_addr = ADDR_W'(int'(emit_port_reg) * FRAME_BYTES + int'(pos_reg));
    end

    assign stat.emit     = emit;
    assign stat.last     = (pos_reg == emit_len_reg - FC_W'(1));
    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_modes_reg    <= '0;
            head_bytes_reg    <= '0;
            tail_bytes_reg    <= '0;
            fixed_length_reg  <= FIXED_LENGTH_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PORT_MODES:    port_modes_reg    <= cfg_data[11:0];
                CFG_HEAD_BYTES:    head_bytes_reg    <= cfg_data[47:0];
                CFG_TAIL_BYTES:    tail_bytes_reg    <= cfg_data[47:0];
                CFG_FIXED_LENGTH:  fixed_length_reg  <= cfg_data[LEN_W-1:0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= in_op;
            port_reg <= in_port;
            byte_reg <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
            for (int i = 0; i < PORTS; i++)
            begin
                fill_reg[i] <= '0;
                seen_reg[i] <= '0;
            end
        end
        else if (cmd.eval)
        begin
            if (op_reg == OP_TICK)
            begin
                tick_reg <= tick_reg + 32'd1;
            end
            else if (port_ok)
            begin
                fill_reg[pidx] <= fill_new;
                seen_reg[pidx] <= tick_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval && wr_en)
        begin
            mem[wr_addr] <= byte_reg;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval && emit)
        begin
            emit_port_reg <= port_reg;
            emit_len_reg  <= emit_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (cmd.eval)
        begin
            pos_reg <= '0;
        end
        else if (cmd.ld)
        begin
            pos_reg <= pos_reg + FC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld)
        begin
            out_port_reg <= emit_port_reg;
            out_byte_reg <= rd_data_reg;
            out_pos_reg  <= POS_W'(pos_reg);
            out_len_reg  <= LEN_W'(emit_len_reg);
            out_last_reg <= stat.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_port  = out_port_reg;
    assign out_byte  = out_byte_reg;
    assign out_pos   = out_pos_reg;
    assign out_len   = out_len_reg;
    assign out_last  = out_last_reg;

endmodule
